// File: hw/rtl/frame_budget_task_throttle_assert.svh
// Assertion macros for the frame budget task throttle checker.
`ifndef FRAME_BUDGET_TASK_THROTTLE_ASSERT_SVH
`define FRAME_BUDGET_TASK_THROTTLE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define FBTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbtt assertion failed: %m");

// Next-cycle implication, clocked on clk, off during rst.
`define FBTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbtt assertion failed: %m");

`endif

// File: hw/rtl/fbtt_pkg.sv
// Shared constants and types of the frame budget task throttle.
package fbtt_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BUDGET_RESET    = 8'd8;
  localparam logic [7:0] FRAME_LEN_RESET = 8'd16;

  localparam logic [1:0] REQ_COMPLETE = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_CHECK    = 2'd2;
  localparam logic [1:0] REQ_ENABLE   = 2'd3;

  localparam logic [1:0] ACT_RUN     = 2'd0;
  localparam logic [1:0] ACT_DEFER   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_DROP    = 2'd3;

  localparam logic [1:0] CFG_BUDGET    = 2'd0;
  localparam logic [1:0] CFG_FRAME_LEN = 2'd1;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

// File: hw/rtl/fbtt_fifo.sv
// Deferral queue: id storage with head/tail pointers and fill count.
module fbtt_fifo import fbtt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  fifo_ctl_t         ctl,
  input  logic [7:0]        push_data,
  output logic [7:0]        pop_data,
  output logic [FILL_W-1:0] fill
);

  logic [7:0]       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= push_data;
    end
    if (ctl.pop) begin
      pop_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (ctl.push) begin
        tail <= wrap_inc(tail);
      end
      if (ctl.pop) begin
        head <= wrap_inc(head);
      end
      // push and pop never share a cycle
      if (ctl.push) begin
        fill <= fill + 1'b1;
      end else if (ctl.pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/frame_budget_task_throttle.sv
// Frame budget task throttle: per-frame rate limiter with a deferral queue.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  request  | start / busy           | req_type, task_id, enable_value
//  result   | result_valid (strobe)  | out_task, action, frame_count, last_of_run
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A tick, a check with no boundary or a disabled completion ends in S_EVAL; an
// enabled completion goes on to S_TAIL, through S_RD first if it crosses a
// boundary; a crossing check or a disable goes on to S_RD. Each released id
// passes S_RD then S_EMIT (one queue read port, registered data). All results
// are registered. Reset is synchronous; the queue needs no clearing pass.
// The receiver cannot stall; cfg_ready is always high.
module frame_budget_task_throttle import fbtt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [7:0] task_id,
  input  logic       enable_value,
  output logic       result_valid,
  output logic [7:0] out_task,
  output logic [1:0] action,
  output logic [7:0] frame_count,
  output logic       last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;

  logic [2:0]  state;
  logic [7:0]  budget;
  logic [7:0]  frame_len;
  logic        enabled;
  logic [7:0]  count;
  logic [15:0] ticks;
  logic [1:0]  req;
  logic [7:0]  task_q;
  logic        en_q;
  logic [7:0]  limit;
  logic [7:0]  done;
  logic        counting;
  logic        tail_op;

  fifo_ctl_t         fctl;
  logic [7:0]        pop_data;
  logic [FILL_W-1:0] fill;
  logic              boundary;
  logic              can_rel;
  logic              has_room;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign boundary  = (ticks >= {8'd0, frame_len});
  assign can_rel   = (fill != '0) && (done < limit);
  assign has_room  = (fill < FILL_W'(QUEUE_DEPTH));

  always_comb begin
    fctl.pop  = (state == S_RD) && can_rel;
    fctl.push = (state == S_TAIL) && !(count < budget) && has_room;
  end

  fbtt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fctl),
    .push_data (task_q),
    .pop_data  (pop_data),
    .fill      (fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      budget    <= BUDGET_RESET;
      frame_len <= FRAME_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BUDGET:    budget    <= cfg_data;
        CFG_FRAME_LEN: frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enabled      <= 1'b1;
      count        <= '0;
      ticks        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req    <= req_type;
            task_q <= task_id;
            en_q   <= enable_value;
            done   <= '0;
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_IDLE;
          unique case (req)
            REQ_COMPLETE: begin
              if (!enabled) begin
                result_valid <= 1'b1;
                out_task     <= task_q;
                action       <= ACT_RUN;
                frame_count  <= count;
                last_of_run  <= 1'b1;
              end else if (boundary) begin
                count    <= '0;
                ticks    <= '0;
                limit    <= budget >> 1;
                counting <= 1'b1;
                tail_op  <= 1'b1;
                state    <= S_RD;
              end else begin
                state <= S_TAIL;
              end
            end
            REQ_TICK: begin
              if (ticks != 16'hFFFF) begin
                ticks <= ticks + 1'b1;
              end
            end
            REQ_CHECK: begin
              if (boundary) begin
                count    <= '0;
                ticks    <= '0;
                limit    <= budget;
                counting <= 1'b1;
                tail_op  <= 1'b0;
                state    <= S_RD;
              end
            end
            REQ_ENABLE: begin
              if (en_q != enabled) begin
                enabled <= en_q;
                if (en_q) begin
                  count <= '0;
                  ticks <= '0;
                end else begin
                  limit    <= 8'(QUEUE_DEPTH);
                  counting <= 1'b0;
                  tail_op  <= 1'b0;
                  state    <= S_RD;
                end
              end
            end
            default: ;
          endcase
        end
        S_RD: begin
          if (can_rel) begin
            done <= done + 1'b1;
            if (counting && count != 8'hFF) begin
              count <= count + 1'b1;
            end
            state <= S_EMIT;
          end else if (tail_op) begin
            state <= S_TAIL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          // fill and done already reflect this pop
          result_valid <= 1'b1;
          out_task     <= pop_data;
          action       <= ACT_RELEASE;
          frame_count  <= count;
          last_of_run  <= !tail_op && !can_rel;
          state        <= S_RD;
        end
        S_TAIL: begin
          result_valid <= 1'b1;
          out_task     <= task_q;
          last_of_run  <= 1'b1;
          if (count < budget) begin
            count       <= count + 1'b1;
            frame_count <= count + 1'b1;
            action      <= ACT_RUN;
          end else begin
            frame_count <= count;
            action      <= has_room ? ACT_DEFER : ACT_DROP;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/fbtt_checker.sv
// Port-level checker for the frame budget task throttle, with its bind.
`include "frame_budget_task_throttle_assert.svh"

module fbtt_checker import fbtt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic [1:0] action,
  input logic       last_of_run
);

  // an accepted request always makes the sequencer busy in the next cycle
  `FBTT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // only queue releases can be followed by more results of the same request
  `FBTT_ASSERT_IMP(a_final_kind, result_valid && action != ACT_RELEASE, last_of_run)
  // a release is never directly followed by another result (one read port, registered data)
  `FBTT_ASSERT_NXT(a_release_gap, result_valid && action == ACT_RELEASE, !result_valid)
  // the closing result of a request is never directly followed by another
  `FBTT_ASSERT_NXT(a_last_gap, result_valid && last_of_run, !result_valid)

endmodule

bind frame_budget_task_throttle fbtt_checker u_fbtt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .action       (action),
  .last_of_run  (last_of_run)
);

// File: tb/frame_budget_task_throttle_test.sv
// Self-checking testbench for the frame budget task throttle.
module frame_budget_task_throttle_test;
  import fbtt_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [1:0] CFG_SPARE2 = 2'd2;
  localparam logic [1:0] CFG_SPARE3 = 2'd3;

  typedef struct packed {
    logic [7:0] id;
    logic [1:0] act;
    logic [7:0] count;
    logic       last;
  } action_t;

  class throttle_scoreboard;
    logic [7:0]  budget;
    logic [7:0]  frame_len;
    logic        enabled;
    logic [7:0]  count;
    logic [15:0] ticks;
    logic [7:0]  deferred [QUEUE_DEPTH];
    int          head;
    int          tail;
    int          fill;
    action_t     step_actions[$];
    action_t     pending_actions[$];
    int          errors;
    int          n_requests;
    int          n_results;
    int          seen [4];

    function new();
      budget    = BUDGET_RESET;
      frame_len = FRAME_LEN_RESET;
      enabled   = 1'b1;
      count     = '0;
      ticks     = '0;
      head      = 0;
      tail      = 0;
      fill      = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] data);
      if (idx == CFG_BUDGET) budget = data;
      else if (idx == CFG_FRAME_LEN) frame_len = data;
    endfunction

    function int pending();
      return pending_actions.size();
    endfunction

    function void add_action(logic [7:0] id, logic [1:0] act);
      action_t a;
      a.id    = id;
      a.act   = act;
      a.count = count;
      a.last  = 1'b0;
      step_actions.push_back(a);
    endfunction

    // Pops up to limit deferred ids; counted releases raise the frame count.
    function void release_ids(int unsigned limit, bit counted);
      int unsigned done;
      logic [7:0] id;
      done = 0;
      while (fill > 0 && done < limit) begin
        id = deferred[head];
        head = (head + 1) % QUEUE_DEPTH;
        fill--;
        done++;
        if (counted && count != 8'hFF) count++;
        add_action(id, ACT_RELEASE);
      end
    endfunction

    function void predict_actions(logic [1:0] kind, logic [7:0] id, logic en);
      bit boundary;
      step_actions.delete();
      n_requests++;
      boundary = ticks >= {8'd0, frame_len};
      case (kind)
        REQ_COMPLETE: begin
          if (!enabled) begin
            add_action(id, ACT_RUN);
          end else begin
            if (boundary) begin
              count = '0;
              ticks = '0;
              release_ids(budget >> 1, 1'b1);
            end
            if (count < budget) begin
              count++;
              add_action(id, ACT_RUN);
            end else if (fill < QUEUE_DEPTH) begin
              deferred[tail] = id;
              tail = (tail + 1) % QUEUE_DEPTH;
              fill++;
              add_action(id, ACT_DEFER);
            end else begin
              add_action(id, ACT_DROP);
            end
          end
        end
        REQ_TICK: begin
          if (ticks != 16'hFFFF) ticks++;
        end
        REQ_CHECK: begin
          if (boundary) begin
            count = '0;
            ticks = '0;
            release_ids(budget, 1'b1);
          end
        end
        REQ_ENABLE: begin
          if (en != enabled) begin
            enabled = en;
            if (en) begin
              count = '0;
              ticks = '0;
            end else begin
              release_ids(QUEUE_DEPTH, 1'b0);
            end
          end
        end
      endcase
      if (step_actions.size() > 0) step_actions[step_actions.size() - 1].last = 1'b1;
      foreach (step_actions[i]) pending_actions.push_back(step_actions[i]);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [7:0] id, logic [1:0] act, logic [7:0] cnt, logic last);
      action_t e;
      if (pending_actions.size() == 0) begin
        report($sformatf("unexpected result task %0d action %0d count %0d", id, act, cnt));
        return;
      end
      e = pending_actions.pop_front();
      n_results++;
      seen[e.act]++;
      if (id !== e.id)
        report($sformatf("result %0d: out_task %0d, expected %0d", n_results, id, e.id));
      if (act !== e.act)
        report($sformatf("result %0d: action %0d, expected %0d", n_results, act, e.act));
      if (cnt !== e.count)
        report($sformatf("result %0d: frame_count %0d, expected %0d", n_results, cnt, e.count));
      if (last !== e.last)
        report($sformatf("result %0d: last_of_run %0b, expected %0b", n_results, last, e.last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] req_type = '0;
  logic [7:0] task_id = '0;
  logic       enable_value = 1'b0;
  logic       result_valid;
  logic [7:0] out_task;
  logic [1:0] action;
  logic [7:0] frame_count;
  logic       last_of_run;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  throttle_scoreboard sb;
  bit quiet = 1'b0;
  int cycles = 0;

  frame_budget_task_throttle dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .task_id      (task_id),
    .enable_value (enable_value),
    .result_valid (result_valid),
    .out_task     (out_task),
    .action       (action),
    .frame_count  (frame_count),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(out_task, action, frame_count, last_of_run);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic [1:0] kind, logic [7:0] id, logic en);
    while (!quiet && $urandom_range(99) < 26) begin
      start = 1'b0;
      req_type = 2'($urandom);
      task_id = 8'($urandom);
      enable_value = 1'($urandom);
      @(negedge clk);
    end
    start = 1'b1;
    req_type = kind;
    task_id = id;
    enable_value = en;
    do @(posedge clk); while (busy);
    sb.predict_actions(kind, id, en);
    @(negedge clk);
  endtask

  // Block idle: nothing owed and enough cycles for a silent request to finish.
  task automatic settle();
    start = 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [7:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_requests(int n);
    int sent;
    int pick;
    int run;
    int span;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        run = $urandom_range(1, 20);
        repeat (run) send_request(REQ_COMPLETE, 8'($urandom), 1'($urandom));
        sent += run;
      end else if (pick < 65) begin
        span = (sb.frame_len > 22) ? 24 : sb.frame_len + 2;
        run = $urandom_range(1, span);
        repeat (run) send_request(REQ_TICK, 8'($urandom), 1'($urandom));
        sent += run;
      end else if (pick < 78) begin
        send_request(REQ_CHECK, 8'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 88) begin
        send_request(REQ_ENABLE, 8'($urandom), $urandom_range(99) < 65);
        sent++;
      end else begin
        send_request(2'($urandom), 8'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0] budgets [7];
    logic [7:0] lengths [7];
    budgets = '{8'd8, 8'd0, 8'd255, 8'd3, 8'd1, 8'd0, 8'd0};
    lengths = '{8'd16, 8'd1, 8'd255, 8'd0, 8'd4, 8'd0, 8'd0};
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: defaults, unchanged enable, disabled pass-through, early check.
    send_request(REQ_COMPLETE, 8'h00, 1'b1);
    send_request(REQ_COMPLETE, 8'hFF, 1'b0);
    send_request(REQ_TICK, 8'h5A, 1'b1);
    send_request(REQ_CHECK, 8'hFF, 1'b1);
    send_request(REQ_ENABLE, 8'hFF, 1'b1);
    send_request(REQ_ENABLE, 8'h00, 1'b0);
    send_request(REQ_COMPLETE, 8'hA5, 1'b1);
    send_request(REQ_TICK, 8'h00, 1'b0);
    send_request(REQ_CHECK, 8'h00, 1'b0);
    send_request(REQ_ENABLE, 8'h3C, 1'b1);
    settle();
    write_register(CFG_BUDGET, 8'd2);
    write_register(CFG_FRAME_LEN, 8'd2);
    // Two run, two deferred; boundary seen on a completion releases budget/2.
    send_request(REQ_COMPLETE, 8'h11, 1'b0);
    send_request(REQ_COMPLETE, 8'h22, 1'b1);
    send_request(REQ_COMPLETE, 8'h33, 1'b0);
    send_request(REQ_COMPLETE, 8'h44, 1'b1);
    send_request(REQ_TICK, 8'hC3, 1'b1);
    send_request(REQ_TICK, 8'h3C, 1'b0);
    send_request(REQ_COMPLETE, 8'h55, 1'b0);
    send_request(REQ_COMPLETE, 8'h66, 1'b1);
    send_request(REQ_TICK, 8'h81, 1'b0);
    send_request(REQ_TICK, 8'h7E, 1'b1);
    send_request(REQ_CHECK, 8'h99, 1'b1);
    send_request(REQ_COMPLETE, 8'h77, 1'b0);
    send_request(REQ_ENABLE, 8'h01, 1'b0);
    send_request(REQ_ENABLE, 8'hFE, 1'b1);

    // Fill the queue past full with a zero budget, then release it all at once.
    settle();
    write_register(CFG_BUDGET, 8'd0);
    write_register(CFG_FRAME_LEN, 8'd4);
    write_register(CFG_SPARE2, 8'hFF);
    send_request(REQ_ENABLE, 8'($urandom), 1'b0);
    send_request(REQ_ENABLE, 8'($urandom), 1'b1);
    repeat (QUEUE_DEPTH + 4) send_request(REQ_COMPLETE, 8'($urandom), 1'($urandom));
    settle();
    write_register(CFG_BUDGET, 8'd255);
    write_register(CFG_SPARE3, 8'h00);
    repeat (4) send_request(REQ_TICK, 8'($urandom), 1'($urandom));
    send_request(REQ_COMPLETE, 8'($urandom), 1'($urandom));

    // Back-to-back stretch with no idling; the check lands before the frame ends.
    settle();
    write_register(CFG_BUDGET, 8'd2);
    write_register(CFG_FRAME_LEN, 8'd255);
    send_request(REQ_ENABLE, 8'($urandom), 1'b0);
    send_request(REQ_ENABLE, 8'($urandom), 1'b1);
    repeat (3) send_request(REQ_COMPLETE, 8'($urandom), 1'($urandom));
    quiet = 1'b1;
    repeat (12) send_request(REQ_TICK, 8'($urandom), 1'($urandom));
    quiet = 1'b0;
    send_request(REQ_CHECK, 8'($urandom), 1'($urandom));

    for (int p = 0; p < 7; p++) begin
      if (p == 5) begin
        budgets[p] = 8'($urandom);
        lengths[p] = 8'($urandom);
      end else if (p == 6) begin
        budgets[p] = 8'($urandom_range(0, 6));
        lengths[p] = 8'($urandom_range(0, 8));
      end
      settle();
      write_register(CFG_BUDGET, budgets[p]);
      write_register(CFG_FRAME_LEN, lengths[p]);
      quiet = (p == 3);
      random_requests(10);
    end
    quiet = 1'b0;

    settle();
    $display("Ran %0d requests, %0d results: %0d run, %0d deferred, %0d released, %0d dropped",
             sb.n_requests, sb.n_results, sb.seen[ACT_RUN], sb.seen[ACT_DEFER],
             sb.seen[ACT_RELEASE], sb.seen[ACT_DROP]);
    $display("Budgets and frame lengths swept from zero to 255, queue filled past full");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/fbtt_pkg.sv
hw/rtl/fbtt_fifo.sv
hw/rtl/frame_budget_task_throttle.sv
hw/rtl/fbtt_checker.sv
tb/frame_budget_task_throttle_test.sv
